[rtl/core/udq_pkg.sv]
// ----------------------------------------------------------------------------
// udq_pkg: shared types and constants for the hop-distance query engine
// Graph size limits, payload structs and the unreached distance code.
// ----------------------------------------------------------------------------
package udq_pkg;

	localparam int unsigned NumVertices = 64;
	localparam int unsigned VtxW        = 6;
	localparam int unsigned CountW      = 7;
	localparam int unsigned DistW       = 7;
	localparam int unsigned TableDepth  = NumVertices * NumVertices;
	localparam int unsigned TableAddrW  = 2 * VtxW;
	localparam int unsigned QueueW      = DistW + VtxW;

	localparam logic [DistW-1:0] Unreached = 7'h7F;

	localparam logic OpWriteEdge = 1'b0;
	localparam logic OpQuery     = 1'b1;

	typedef struct packed {
		logic            operation;
		logic [VtxW-1:0] from_vertex;
		logic [VtxW-1:0] to_vertex;
		logic            edge_present;
	} udq_in_t;

	typedef struct packed {
		logic [VtxW-1:0] hop_distance;
		logic            reachable;
	} udq_out_t;

endpackage

[rtl/core/unweighted_distance_query.sv]
// ----------------------------------------------------------------------------
// unweighted_distance_query: hop-distance query engine
// All-pairs breadth-first search over a 64-vertex adjacency bit matrix.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data): edge writes and distance queries.
//   An edge write reads and writes back one adjacency row, produces no
//   transfer on the output, and marks the distance cache stale.
//   A query returns one out transfer (hop_distance, reachable).
//   cfg channel (cfg_valid/cfg_ready/cfg_data): active_vertices, ready only
//   while idle; any write marks the cache stale.
//   A cached query issues its table read in StQuery and registers the
//   result and out_valid in StQueryWait. A query that finds the cache
//   stale first rebuilds it: per source, StFill writes its row with the
//   unreached code (zero at the source) and queues the source; each
//   dequeued vertex passes pop, queue read and row read, then the single
//   shared neighbor test/update unit tests each active vertex in turn;
//   StNextSrc closes the source. The block takes one item at a time;
//   in_ready is low while busy.
//   The out register holds its result while the receiver stalls; the next
//   item is accepted in the same cycle the result is taken.
//   Reset: empty graph, cache stale, active_vertices = 64.
module unweighted_distance_query (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  udq_pkg::udq_in_t    in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output udq_pkg::udq_out_t   out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [6:0]          cfg_data
);
	import udq_pkg::*;

	typedef enum logic [3:0] {
		StIdle, StEdge, StFill, StPop, StRow, StLoad, StScan, StNextSrc,
		StQuery, StQueryWait, StOut
	} state_t;

	state_t state_q;

	logic [CountW-1:0] active_q;
	logic              stale_q;
	udq_in_t           item_q;
	logic [NumVertices-1:0] adj_valid_q; // adjacency row written since reset
	logic              adj_rv_q;        // valid mark of the row being read
	logic [NumVertices-1:0] row_q;      // adjacency row of vertex being expanded
	logic [NumVertices-1:0] seen_q;     // visited marks for current source
	logic [VtxW-1:0]   src_q;
	logic [VtxW-1:0]   j_q;             // scan / fill index
	logic [DistW-1:0]  du_q;            // distance of u
	logic [CountW-1:0] head_q, tail_q;

	// live count: clamp to 1..64
	logic [CountW-1:0] n_live;
	logic [VtxW-1:0]   last_v;
	always_comb begin
		n_live = (active_q == '0) ? CountW'(1) : active_q;
		if (n_live > CountW'(NumVertices)) n_live = CountW'(NumVertices);
		last_v = VtxW'(n_live - CountW'(1));
	end

	// distance table RAM
	logic                  tbl_we;
	logic [TableAddrW-1:0] tbl_waddr, tbl_raddr;
	logic [DistW-1:0]      tbl_wdata, tbl_rdata;

	udq_ram #(.Width(DistW), .Depth(TableDepth)) u_table (
		.clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.raddr(tbl_raddr), .rdata(tbl_rdata)
	);

	// search queue RAM: {distance, vertex} per entry
	logic              q_we;
	logic [VtxW-1:0]   q_waddr, q_raddr;
	logic [QueueW-1:0] q_wdata, q_rdata;

	udq_ram #(.Width(QueueW), .Depth(NumVertices)) u_queue (
		.clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	// adjacency RAM, one row per tail vertex
	logic                   adj_we;
	logic [VtxW-1:0]        adj_waddr, adj_raddr;
	logic [NumVertices-1:0] adj_wdata, adj_rdata;

	udq_ram #(.Width(NumVertices), .Depth(NumVertices)) u_adj (
		.clk, .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
		.raddr(adj_raddr), .rdata(adj_rdata)
	);

	// edge write: old row (zero if never written) with one bit replaced
	logic [NumVertices-1:0] edge_row;
	always_comb begin
		edge_row = adj_rv_q ? adj_rdata : '0;
		edge_row[item_q.to_vertex] = item_q.edge_present;
	end

	// shared neighbor unit: test candidate j_q
	logic hit;
	assign hit = row_q[j_q] && !seen_q[j_q];

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = {src_q, j_q};
		tbl_wdata = Unreached;
		q_we      = 1'b0;
		q_waddr   = tail_q[VtxW-1:0];
		q_wdata   = {du_q + DistW'(1), j_q};
		adj_we    = 1'b0;
		adj_waddr = item_q.from_vertex;
		adj_wdata = edge_row;
		adj_raddr = in_data.from_vertex;
		case (state_q)
			StFill: begin
				tbl_we    = 1'b1;
				tbl_wdata = (j_q == src_q) ? '0 : Unreached;
				if (j_q == last_v) begin
					q_we    = 1'b1;
					q_waddr = '0;
					q_wdata = {DistW'(0), src_q};
				end
			end
			StScan: begin
				tbl_we    = hit;
				tbl_wdata = du_q + DistW'(1);
				q_we      = hit;
			end
			StEdge: adj_we = 1'b1;
			StRow: adj_raddr = q_rdata[VtxW-1:0];
			default: ;
		endcase
		q_raddr   = head_q[VtxW-1:0];
		tbl_raddr = {item_q.from_vertex, item_q.to_vertex};
	end

	assign in_ready  = (state_q == StIdle) || (state_q == StOut && out_ready);
	assign cfg_ready = (state_q == StIdle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			active_q    <= CountW'(NumVertices);
			stale_q     <= 1'b1;
			out_valid   <= 1'b0;
			adj_valid_q <= '0;
			adj_rv_q    <= 1'b0;
		end else begin
			adj_rv_q <= adj_valid_q[adj_raddr];
			if (cfg_valid && cfg_ready) begin
				active_q <= cfg_data;
				stale_q  <= 1'b1;
			end
			case (state_q)
				StIdle, StOut: begin
					if (state_q == StOut && out_ready) out_valid <= 1'b0;
					if (in_valid && in_ready) begin
						item_q <= in_data;
						if (in_data.operation == OpWriteEdge) begin
							state_q <= StEdge;
						end else if (stale_q || (cfg_valid && cfg_ready)) begin
							src_q   <= '0;
							j_q     <= '0;
							seen_q  <= NumVertices'(1);
							state_q <= StFill;
						end else begin
							state_q <= StQuery;
						end
					end else if (state_q == StOut && out_ready) begin
						state_q <= StIdle;
					end
				end
				StEdge: begin
					adj_valid_q[item_q.from_vertex] <= 1'b1;
					stale_q <= 1'b1;
					state_q <= StIdle;
				end
				StFill: begin
					if (j_q == last_v) begin
						head_q  <= '0;
						tail_q  <= CountW'(1);
						state_q <= StPop;
					end else begin
						j_q <= j_q + VtxW'(1);
					end
				end
				StPop: begin
					// queue read issued at head_q
					if (head_q == tail_q) begin
						state_q <= StNextSrc;
					end else begin
						head_q  <= head_q + CountW'(1);
						state_q <= StRow;
					end
				end
				StRow: begin
					// row read issued at the dequeued vertex
					du_q    <= q_rdata[QueueW-1:VtxW];
					state_q <= StLoad;
				end
				StLoad: begin
					row_q   <= adj_rv_q ? adj_rdata : '0;
					j_q     <= '0;
					state_q <= StScan;
				end
				StScan: begin
					if (hit) begin
						seen_q[j_q] <= 1'b1;
						tail_q <= tail_q + CountW'(1);
					end
					if (j_q == last_v) begin
						state_q <= StPop;
					end else begin
						j_q <= j_q + VtxW'(1);
					end
				end
				StNextSrc: begin
					if (src_q == last_v) begin
						stale_q <= 1'b0;
						state_q <= StQuery;
					end else begin
						src_q   <= src_q + VtxW'(1);
						j_q     <= '0;
						seen_q  <= NumVertices'(1) << (src_q + VtxW'(1));
						state_q <= StFill;
					end
				end
				StQuery: state_q <= StQueryWait;
				StQueryWait: begin
					if ({1'b0, item_q.from_vertex} < n_live &&
					    {1'b0, item_q.to_vertex} < n_live &&
					    tbl_rdata != Unreached) begin
						out_data.hop_distance <= tbl_rdata[VtxW-1:0];
						out_data.reachable    <= 1'b1;
					end else begin
						out_data.hop_distance <= '0;
						out_data.reachable    <= 1'b0;
					end
					out_valid <= 1'b1;
					state_q   <= StOut;
				end
				default: state_q <= StIdle;
			endcase
		end
	end
endmodule

[rtl/core/udq_ram.sv]
// ----------------------------------------------------------------------------
// udq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module udq_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/core/udq_checker.sv]
// ----------------------------------------------------------------------------
// udq_checker: port-level checks for unweighted_distance_query
// Watches handshakes and result sanity on the top level's ports.
// ----------------------------------------------------------------------------
module udq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input udq_pkg::udq_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input udq_pkg::udq_out_t out_data
);
	import udq_pkg::*;

	// an unreachable result always reports distance zero
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.reachable |-> out_data.hop_distance == '0)
		else $error("unreachable result with nonzero distance");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// an edge write never yields a result next cycle
	a_edge_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.operation == OpWriteEdge |=> !out_valid)
		else $error("result after edge write");

	// the block takes no item while busy with one (ready only idle or draining)
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted back to back");
endmodule

bind unweighted_distance_query udq_checker u_udq_checker (
	.clk, .arst_n, .in_valid, .in_ready, .in_data,
	.out_valid, .out_ready, .out_data
);
